>>> rtl/rbfi_pkg.sv
// ---------------------------------------------------------------------------
// rbfi_pkg
// Types, constants and saturation helpers shared by the rigid body friction
// integrator modules.
// ---------------------------------------------------------------------------
package rbfi_pkg;

    localparam int VALUE_W   = 32;
    localparam int FRAC_B    = 16;
    localparam int PROD_W    = 2 * VALUE_W;
    localparam int CFG_IDX_W = 2;
    localparam int CNT_W     = 6;
    localparam int DIV_STEPS  = PROD_W;
    localparam int SQRT_STEPS = PROD_W / 2;

    localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(DIV_STEPS - 1);
    localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(SQRT_STEPS - 1);

    localparam logic [CFG_IDX_W-1:0] CFG_MASS     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRICTION = 2'd1;

    localparam logic [VALUE_W-1:0] MASS_RESET     = VALUE_W'(1) << FRAC_B;
    localparam logic [VALUE_W-1:0] FRICTION_RESET = VALUE_W'(400) << FRAC_B;

    localparam logic [PROD_W-1:0] POS_LIM = (PROD_W'(1) << (VALUE_W - 1)) - PROD_W'(1);
    localparam logic [PROD_W-1:0] NEG_LIM = PROD_W'(1) << (VALUE_W - 1);

    typedef logic signed [VALUE_W-1:0] fix_t;
    typedef logic        [VALUE_W-1:0] ufix_t;

    typedef struct packed {
        fix_t  force_x;
        fix_t  force_y;
        fix_t  force_z;
        ufix_t time_step;
        fix_t  pos_x;
        fix_t  pos_y;
        fix_t  pos_z;
        logic  has_position;
    } in_item_t;

    typedef struct packed {
        fix_t new_pos_x;
        fix_t new_pos_y;
        fix_t new_pos_z;
        fix_t vel_x;
        fix_t vel_y;
        fix_t vel_z;
    } out_item_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_ACC_INIT,
        OP_DIV_STEP,
        OP_ACC_END,
        OP_FR_MUL0,
        OP_FR_MUL1,
        OP_FR_MUL2,
        OP_FR_END,
        OP_SQ_MUL,
        OP_SQ_ADD,
        OP_SQRT_INIT,
        OP_SQRT_STEP,
        OP_ZERO_VEL,
        OP_FRIC_MUL,
        OP_FRIC_INIT,
        OP_FRIC_END,
        OP_POS_MUL,
        OP_POS_END,
        OP_OUT_LOAD
    } op_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ACC_INIT,
        ST_ACC_DIV,
        ST_ACC_END,
        ST_CHECK,
        ST_FR0,
        ST_FR1,
        ST_FR2,
        ST_FR3,
        ST_SQ_MUL,
        ST_SQ_ADD,
        ST_SQRT_INIT,
        ST_SQRT,
        ST_CMP,
        ST_FM_MUL,
        ST_FM_INIT,
        ST_FM_DIV,
        ST_FM_END,
        ST_POS_MUL,
        ST_POS_END,
        ST_DONE
    } state_t;

    typedef struct packed {
        op_t        op;
        logic [1:0] idx;
    } cmd_t;

    typedef struct packed {
        logic any_nz;
        logic slow;
    } status_t;

    function automatic ufix_t mag(input fix_t v);
        return v[VALUE_W-1] ? ufix_t'(-v) : ufix_t'(v);
    endfunction

    function automatic fix_t sat_signed(input logic neg, input logic [PROD_W-1:0] m);
        if (!neg) begin
            return (m > POS_LIM) ? {1'b0, {(VALUE_W-1){1'b1}}} : fix_t'(m[VALUE_W-1:0]);
        end
        if (m >= NEG_LIM) begin
            return {1'b1, {(VALUE_W-1){1'b0}}};
        end
        return -fix_t'(m[VALUE_W-1:0]);
    endfunction

    function automatic fix_t sat_add(input fix_t a, input fix_t b);
        logic [VALUE_W:0] s;
        s = {a[VALUE_W-1], a} + {b[VALUE_W-1], b};
        if (s[VALUE_W] != s[VALUE_W-1]) begin
            return s[VALUE_W] ? {1'b1, {(VALUE_W-1){1'b0}}} : {1'b0, {(VALUE_W-1){1'b1}}};
        end
        return fix_t'(s[VALUE_W-1:0]);
    endfunction

endpackage

>>> rtl/rbfi_datapath.sv
// ---------------------------------------------------------------------------
// rbfi_datapath
// Configuration registers and, stepped by controller commands, velocity
// state, shared multiplier, restoring divider and square root.
// ---------------------------------------------------------------------------
module rbfi_datapath
    import rbfi_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [VALUE_W-1:0]   cfg_data,
    input  in_item_t             in_item,
    input  cmd_t                 cmd,
    output status_t              status,
    output out_item_t            out_item
);

    localparam int FT_W = PROD_W + FRAC_B + 1;

    ufix_t                mass_reg, friction_reg;
    in_item_t             in_reg;
    fix_t                 vel_reg [3];
    fix_t                 np_reg  [3];
    logic [PROD_W-1:0]    prod_reg, p0_reg, ss_reg, quo_reg;
    logic [VALUE_W-FRAC_B-1:0] thi_reg;
    ufix_t                den_reg, rem_reg, root_reg, fr_reg;
    logic [VALUE_W+1:0]   srem_reg;
    out_item_t            out_reg;

    ufix_t             mul_a, mul_b;
    fix_t              force_sel, pos_sel, vel_sel;
    ufix_t             vmag;
    logic [VALUE_W:0]  div_sh;
    logic              div_ge;
    logic [VALUE_W+3:0] sq_sh, sq_trial;
    logic              sq_ge;
    logic [FT_W-1:0]   ftot, fsh;
    fix_t              acc;
    ufix_t             fd, fm;
    fix_t              step;

    always_comb begin
        case (cmd.idx)
            2'd0:    begin force_sel = in_reg.force_x; pos_sel = in_reg.pos_x; end
            2'd1:    begin force_sel = in_reg.force_y; pos_sel = in_reg.pos_y; end
            default: begin force_sel = in_reg.force_z; pos_sel = in_reg.pos_z; end
        endcase
        vel_sel = vel_reg[cmd.idx];
        vmag    = mag(vel_sel);
    end

    always_comb begin
        mul_a = vmag;
        mul_b = vmag;
        case (cmd.op)
            OP_FR_MUL0: begin mul_a = friction_reg; mul_b = in_reg.time_step; end
            OP_FR_MUL1: begin mul_a = prod_reg[FRAC_B+VALUE_W-1:FRAC_B]; mul_b = mass_reg; end
            OP_FR_MUL2: begin mul_a = VALUE_W'(thi_reg); mul_b = mass_reg; end
            OP_FRIC_MUL: mul_b = fr_reg;
            OP_POS_MUL:  mul_b = in_reg.time_step;
            default: ;
        endcase
    end

    // divider and square root steps, and the friction product sum
    always_comb begin
        div_sh   = {rem_reg, quo_reg[PROD_W-1]};
        div_ge   = div_sh >= {1'b0, den_reg};
        sq_sh    = {srem_reg, quo_reg[PROD_W-1:PROD_W-2]};
        sq_trial = {2'b00, root_reg, 2'b01};
        sq_ge    = sq_sh >= sq_trial;
        ftot     = FT_W'(p0_reg) + (FT_W'(prod_reg) << VALUE_W);
        fsh      = ftot >> FRAC_B;
    end

    always_comb begin
        if (force_sel == '0) begin
            acc = '0;
        end else if (mass_reg == '0) begin
            acc = force_sel[VALUE_W-1] ? {1'b1, {(VALUE_W-1){1'b0}}}
                                       : {1'b0, {(VALUE_W-1){1'b1}}};
        end else begin
            acc = sat_signed(force_sel[VALUE_W-1], quo_reg);
        end
        fd   = (quo_reg > PROD_W'(vmag)) ? vmag : quo_reg[VALUE_W-1:0];
        fm   = vmag - fd;
        step = sat_signed(vel_sel[VALUE_W-1], prod_reg >> FRAC_B);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mass_reg     <= MASS_RESET;
            friction_reg <= FRICTION_RESET;
        end else if (cfg_we) begin
            if (cfg_index == CFG_MASS) mass_reg <= cfg_data;
            if (cfg_index == CFG_FRICTION) friction_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vel_reg[0] <= '0;
            vel_reg[1] <= '0;
            vel_reg[2] <= '0;
        end else begin
            case (cmd.op)
                OP_ACC_END:  vel_reg[cmd.idx] <= sat_add(vel_sel, acc);
                OP_ZERO_VEL: begin
                    vel_reg[0] <= '0;
                    vel_reg[1] <= '0;
                    vel_reg[2] <= '0;
                end
                OP_FRIC_END: vel_reg[cmd.idx] <= vel_sel[VALUE_W-1] ? -fix_t'(fm) : fix_t'(fm);
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
        case (cmd.op)
            OP_LOAD:     in_reg <= in_item;
            OP_ACC_INIT: begin
                quo_reg <= PROD_W'(mag(force_sel)) << FRAC_B;
                rem_reg <= '0;
                den_reg <= mass_reg;
            end
            OP_DIV_STEP: begin
                rem_reg <= div_ge ? VALUE_W'(div_sh - {1'b0, den_reg}) : div_sh[VALUE_W-1:0];
                quo_reg <= {quo_reg[PROD_W-2:0], div_ge};
            end
            OP_FR_MUL0:  ss_reg  <= '0;
            OP_FR_MUL1:  thi_reg <= prod_reg[PROD_W-1:FRAC_B+VALUE_W];
            OP_FR_MUL2:  p0_reg  <= prod_reg;
            OP_FR_END:   fr_reg  <= (|fsh[FT_W-1:VALUE_W]) ? '1 : fsh[VALUE_W-1:0];
            OP_SQ_ADD:   ss_reg  <= ss_reg + prod_reg;
            OP_SQRT_INIT: begin
                quo_reg  <= ss_reg;
                srem_reg <= '0;
                root_reg <= '0;
            end
            OP_SQRT_STEP: begin
                srem_reg <= sq_ge ? (VALUE_W+2)'(sq_sh - sq_trial) : sq_sh[VALUE_W+1:0];
                root_reg <= {root_reg[VALUE_W-2:0], sq_ge};
                quo_reg  <= {quo_reg[PROD_W-3:0], 2'b00};
            end
            OP_FRIC_INIT: begin
                quo_reg <= prod_reg;
                rem_reg <= '0;
                den_reg <= root_reg;
            end
            OP_POS_END:  np_reg[cmd.idx] <= in_reg.has_position ? sat_add(pos_sel, step) : '0;
            OP_OUT_LOAD: begin
                out_reg.new_pos_x <= np_reg[0];
                out_reg.new_pos_y <= np_reg[1];
                out_reg.new_pos_z <= np_reg[2];
                out_reg.vel_x     <= vel_reg[0];
                out_reg.vel_y     <= vel_reg[1];
                out_reg.vel_z     <= vel_reg[2];
            end
            default: ;
        endcase
    end

    assign status.any_nz = (vel_reg[0] != '0) || (vel_reg[1] != '0) || (vel_reg[2] != '0);
    assign status.slow   = root_reg < fr_reg;
    assign out_item      = out_reg;

endmodule

>>> rtl/rbfi_ctrl.sv
// ---------------------------------------------------------------------------
// rbfi_ctrl
// Sequencer: walks one tick through acceleration, friction and position
// phases and owns both channel handshakes.
// ---------------------------------------------------------------------------
module rbfi_ctrl
    import rbfi_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    output logic    m_valid,
    input  logic    m_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [1:0]        k_reg, k_next;
    logic              m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            k_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            k_reg       <= k_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        k_next       = k_reg;
        m_valid_next = m_valid_reg && !m_ready;
        s_ready      = 1'b0;
        cmd.op       = OP_NONE;
        cmd.idx      = k_reg;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op     = OP_LOAD;
                    k_next     = 2'd0;
                    state_next = ST_ACC_INIT;
                end
            end
            ST_ACC_INIT: begin
                cmd.op     = OP_ACC_INIT;
                cnt_next   = '0;
                state_next = ST_ACC_DIV;
            end
            ST_ACC_DIV: begin
                cmd.op   = OP_DIV_STEP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST) state_next = ST_ACC_END;
            end
            ST_ACC_END: begin
                cmd.op = OP_ACC_END;
                if (k_reg == 2'd2) begin
                    k_next     = 2'd0;
                    state_next = ST_CHECK;
                end else begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_ACC_INIT;
                end
            end
            ST_CHECK:  state_next = status.any_nz ? ST_FR0 : ST_POS_MUL;
            ST_FR0: begin
                cmd.op     = OP_FR_MUL0;
                state_next = ST_FR1;
            end
            ST_FR1: begin
                cmd.op     = OP_FR_MUL1;
                state_next = ST_FR2;
            end
            ST_FR2: begin
                cmd.op     = OP_FR_MUL2;
                state_next = ST_FR3;
            end
            ST_FR3: begin
                cmd.op     = OP_FR_END;
                state_next = ST_SQ_MUL;
            end
            ST_SQ_MUL: begin
                cmd.op     = OP_SQ_MUL;
                state_next = ST_SQ_ADD;
            end
            ST_SQ_ADD: begin
                cmd.op = OP_SQ_ADD;
                if (k_reg == 2'd2) begin
                    k_next     = 2'd0;
                    state_next = ST_SQRT_INIT;
                end else begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_SQ_MUL;
                end
            end
            ST_SQRT_INIT: begin
                cmd.op     = OP_SQRT_INIT;
                cnt_next   = '0;
                state_next = ST_SQRT;
            end
            ST_SQRT: begin
                cmd.op   = OP_SQRT_STEP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == SQRT_LAST) state_next = ST_CMP;
            end
            ST_CMP: begin
                k_next = 2'd0;
                if (status.slow) begin
                    cmd.op     = OP_ZERO_VEL;
                    state_next = ST_POS_MUL;
                end else begin
                    state_next = ST_FM_MUL;
                end
            end
            ST_FM_MUL: begin
                cmd.op     = OP_FRIC_MUL;
                state_next = ST_FM_INIT;
            end
            ST_FM_INIT: begin
                cmd.op     = OP_FRIC_INIT;
                cnt_next   = '0;
                state_next = ST_FM_DIV;
            end
            ST_FM_DIV: begin
                cmd.op   = OP_DIV_STEP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST) state_next = ST_FM_END;
            end
            ST_FM_END: begin
                cmd.op = OP_FRIC_END;
                if (k_reg == 2'd2) begin
                    k_next     = 2'd0;
                    state_next = ST_POS_MUL;
                end else begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_FM_MUL;
                end
            end
            ST_POS_MUL: begin
                cmd.op     = OP_POS_MUL;
                state_next = ST_POS_END;
            end
            ST_POS_END: begin
                cmd.op = OP_POS_END;
                if (k_reg == 2'd2) begin
                    k_next     = 2'd0;
                    state_next = ST_DONE;
                end else begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_POS_MUL;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.op       = OP_OUT_LOAD;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign m_valid = m_valid_reg;

endmodule

>>> rtl/rigid_body_friction_integrator.sv
// ---------------------------------------------------------------------------
// rigid_body_friction_integrator
// Explicit Euler step with kinetic friction on a kept 3D velocity, Q16.16.
// ---------------------------------------------------------------------------
// One tick beat is taken at a time. A tick is shortest when the velocity ends
// up zero after the force is added, longer when friction stops the body, and
// longest when the body keeps moving. The time is set by the shared restoring
// divider (run per component for the acceleration and again for the friction
// step) and the bit-serial square root behind the speed. The result sits in an
// output register, so the next tick beat is accepted while a finished result
// still waits for m_ready.
// Configuration writes (mass at index 0, friction at index 1, other indexes
// dropped) are always taken; issue them only while the block is idle.
// ---------------------------------------------------------------------------
module rigid_body_friction_integrator
    import rbfi_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // tick channel
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_item_t             s_data,
    // result channel
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_item_t            m_data,
    // configuration write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [VALUE_W-1:0]   cfg_data
);

    cmd_t    cmd;
    status_t status;

    // register writes never stall
    assign cfg_ready = 1'b1;

    // sequencer: advance phase by phase, holding the divider and root phases until their counter runs out
    rbfi_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // arithmetic, configuration and velocity state, and the output register
    rbfi_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_item   (s_data),
        .cmd       (cmd),
        .status    (status),
        .out_item  (m_data)
    );

endmodule

>>> verif/tb_rigid_body_friction_integrator.sv
// ---------------------------------------------------------------------------
// tb_rigid_body_friction_integrator
// Self-checking bench for the Q16.16 Euler integrator with kinetic friction.
// A directed table covers the field extremes, zero and extreme mass and
// friction, the body being stopped by friction, saturation and dropped
// register writes. Random ticks then run under several register settings.
// Each result is checked against its typed value or a bit-exact
// predictor of the kept velocity. Both handshakes idle in random bursts,
// and one long receiver hold-off fills the block and stalls its input.
// ---------------------------------------------------------------------------
module tb_rigid_body_friction_integrator
    import rbfi_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;   // not mapped, dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;   // not mapped, dropped
    localparam fix_t FIX_MAX = 32'sh7fff_ffff;
    localparam fix_t FIX_MIN = 32'sh8000_0000;
    localparam fix_t ONE     = 32'sh0001_0000;
    localparam int   RANDOM_TICKS = 1200;
    localparam int   CALM_TAIL    = 150;      // last ticks run with no idling
    localparam int   LONG_HOLD    = 4000;     // receiver hold-off, in cycles
    localparam int   CYCLE_LIMIT  = 3_000_000;
    localparam int   DRAIN_CYCLES = 500;      // a little over the slowest tick

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    in_item_t             s_data = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    out_item_t            m_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [VALUE_W-1:0]   cfg_data = '0;

    always #5 aclk = ~aclk;

    rigid_body_friction_integrator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // -----------------------------------------------------------------------
    // Predictor state: a private copy of the registers and the kept velocity
    // -----------------------------------------------------------------------
    ufix_t     mass_reg;
    ufix_t     fric_reg;
    fix_t      vel_state [3];
    out_item_t body_states_due [$];

    int  ticks_sent    = 0;
    int  states_seen   = 0;
    int  reg_writes    = 0;
    int  mismatches    = 0;
    int  cycles        = 0;
    bit  calm          = 1'b0;   // set for the tail of the run: no idling
    bit  hold_done     = 1'b0;

    function automatic logic [63:0] abs64(input fix_t v);
        longint w;
        w = v;
        return (w < 0) ? 64'(-w) : 64'(w);
    endfunction

    // Clamp a magnitude with a sign onto the signed 32-bit range
    function automatic fix_t clamp_signed(input bit neg, input logic [127:0] m);
        if (!neg) begin
            return (m > 128'h7fff_ffff) ? FIX_MAX : fix_t'(m[31:0]);
        end
        if (m >= 128'h8000_0000) begin
            return FIX_MIN;
        end
        return -fix_t'(m[31:0]);
    endfunction

    function automatic fix_t add_clamped(input fix_t a, input fix_t b);
        longint s;
        s = longint'(a) + longint'(b);
        if (s > longint'(FIX_MAX)) return FIX_MAX;
        if (s < longint'(FIX_MIN)) return FIX_MIN;
        return fix_t'(s);
    endfunction

    function automatic logic [63:0] floor_sqrt(input logic [127:0] n);
        logic [63:0] r;
        logic [63:0] c;
        r = '0;
        for (int b = 32; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if ({64'd0, c} * {64'd0, c} <= n) r = c;
        end
        return r;
    endfunction

    // Advance the body by one tick and return the state it reports
    function automatic out_item_t advance_body(input in_item_t t);
        fix_t         forces [3];
        fix_t         positions [3];
        fix_t         acc;
        fix_t         moved [3];
        logic [127:0] quot;
        logic [127:0] drag;
        logic [127:0] sumsq;
        logic [127:0] cut;
        logic [63:0]  speed;
        logic [63:0]  m;
        bit           moving;
        out_item_t    r;
        forces    = '{t.force_x, t.force_y, t.force_z};
        positions = '{t.pos_x, t.pos_y, t.pos_z};
        moving    = 1'b0;
        for (int i = 0; i < 3; i++) begin
            if (forces[i] == 0) begin
                acc = 0;
            end else if (mass_reg == 0) begin
                acc = (forces[i] < 0) ? FIX_MIN : FIX_MAX;
            end else begin
                quot = ({64'd0, abs64(forces[i])} << FRAC_B) / mass_reg;
                acc  = clamp_signed(forces[i] < 0, quot);
            end
            vel_state[i] = add_clamped(vel_state[i], acc);
            if (vel_state[i] != 0) moving = 1'b1;
        end
        if (moving) begin
            drag = ((({96'd0, fric_reg} * t.time_step) >> FRAC_B) * mass_reg) >> FRAC_B;
            if (drag > 128'hffff_ffff) drag = 128'hffff_ffff;
            sumsq = '0;
            for (int i = 0; i < 3; i++) begin
                sumsq += {64'd0, abs64(vel_state[i])} * abs64(vel_state[i]);
            end
            speed = floor_sqrt(sumsq);
            if ({64'd0, speed} < drag) begin
                vel_state = '{0, 0, 0};
            end else if (speed != 0) begin
                // pull each component back along the direction of motion
                for (int i = 0; i < 3; i++) begin
                    m   = abs64(vel_state[i]);
                    cut = ({64'd0, m} * drag) / speed;
                    if (cut > m) cut = m;
                    m = m - cut[63:0];
                    vel_state[i] = (vel_state[i] < 0) ? -fix_t'(m[31:0]) : fix_t'(m[31:0]);
                end
            end
        end
        for (int i = 0; i < 3; i++) begin
            moved[i] = 0;
            if (t.has_position) begin
                acc = clamp_signed(vel_state[i] < 0,
                                   ({64'd0, abs64(vel_state[i])} * t.time_step) >> FRAC_B);
                moved[i] = add_clamped(positions[i], acc);
            end
        end
        r.new_pos_x = moved[0];
        r.new_pos_y = moved[1];
        r.new_pos_z = moved[2];
        r.vel_x     = vel_state[0];
        r.vel_y     = vel_state[1];
        r.vel_z     = vel_state[2];
        return r;
    endfunction

    // -----------------------------------------------------------------------
    // Result checking: oldest expectation first, field by field
    // -----------------------------------------------------------------------
    function automatic void check_field(input string name, input fix_t want, input fix_t got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("MISMATCH result %0d %s: expected %h, got %h",
                         states_seen, name, want, got);
            end
        end
    endfunction

    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (body_states_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("MISMATCH unexpected result %h", m_data);
                end
            end else begin
                want = body_states_due.pop_front();
                check_field("new_pos_x", want.new_pos_x, m_data.new_pos_x);
                check_field("new_pos_y", want.new_pos_y, m_data.new_pos_y);
                check_field("new_pos_z", want.new_pos_z, m_data.new_pos_z);
                check_field("vel_x", want.vel_x, m_data.vel_x);
                check_field("vel_y", want.vel_y, m_data.vel_y);
                check_field("vel_z", want.vel_z, m_data.vel_z);
            end
            states_seen++;
        end
    end

    // -----------------------------------------------------------------------
    // Receiver: random stall bursts, one long hold-off to back the block up,
    // and a steady m_ready over the calm tail
    // -----------------------------------------------------------------------
    int stall_left = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (!hold_done && ticks_sent >= 300) begin
            hold_done  <= 1'b1;
            stall_left <= LONG_HOLD;
            m_ready    <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if (!calm && $urandom_range(0, 19) == 0) begin
            stall_left <= $urandom_range(1, 15) - 1;
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, body_states_due.size());
            $display("rigid_body_friction_integrator regression: fail");
            $finish;
        end
    end

    // -----------------------------------------------------------------------
    // Sender side
    // -----------------------------------------------------------------------
    // Offer one tick beat; hold it until taken, then maybe drop valid for a gap
    task automatic send_tick(input in_item_t t, input bit typed, input out_item_t want);
        out_item_t predicted;
        s_valid <= 1'b1;
        s_data  <= t;
        do @(posedge aclk); while (!s_ready);
        predicted = advance_body(t);
        body_states_due.push_back(typed ? want : predicted);
        ticks_sent++;
        if (!calm && $urandom_range(0, 9) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
    endtask

    // Write a register once the block has gone quiet
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input ufix_t value);
        s_valid <= 1'b0;
        wait (body_states_due.size() == 0);
        repeat (8) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_MASS) mass_reg = value;
        else if (idx == CFG_FRICTION) fric_reg = value;
        reg_writes++;
    endtask

    function automatic fix_t rand_force();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return fix_t'($urandom_range(0, 1) ? FIX_MAX : FIX_MIN);
            2: return fix_t'($urandom());
            3: return fix_t'($urandom_range(0, 32'h0008_0000)) - fix_t'(32'h0004_0000);
            default: return fix_t'($urandom_range(0, 32'h0200_0000)) - fix_t'(32'h0100_0000);
        endcase
    endfunction

    function automatic ufix_t rand_step();
        case ($urandom_range(0, 4))
            0: return ufix_t'($urandom());
            1: return ufix_t'($urandom_range(0, 32'h0001_0000));
            default: return ufix_t'($urandom_range(0, 32'h0000_0200));
        endcase
    endfunction

    function automatic in_item_t rand_tick();
        in_item_t t;
        t.force_x      = rand_force();
        t.force_y      = rand_force();
        t.force_z      = rand_force();
        t.time_step    = rand_step();
        t.pos_x        = fix_t'($urandom());
        t.pos_y        = fix_t'($urandom());
        t.pos_z        = fix_t'($urandom());
        t.has_position = $urandom_range(0, 3) != 0;
        return t;
    endfunction

    // -----------------------------------------------------------------------
    // Directed table
    // -----------------------------------------------------------------------
    typedef struct {
        bit                   is_write;
        logic [CFG_IDX_W-1:0] idx;
        ufix_t                value;
        in_item_t             tick;
        bit                   typed;
        out_item_t            want;
    } step_row_t;

    step_row_t plan [$];

    function automatic in_item_t mk_tick(input fix_t fx, input fix_t fy, input fix_t fz,
                                         input ufix_t dt, input fix_t px, input fix_t py,
                                         input fix_t pz, input logic hp);
        in_item_t t;
        t = '{fx, fy, fz, dt, px, py, pz, hp};
        return t;
    endfunction

    function automatic void plan_tick(input in_item_t t, input bit typed, input out_item_t want);
        step_row_t r;
        r = '{1'b0, CFG_MASS, '0, t, typed, want};
        plan.push_back(r);
    endfunction

    function automatic void plan_write(input logic [CFG_IDX_W-1:0] idx, input ufix_t value);
        step_row_t r;
        r = '{1'b1, idx, value, '0, 1'b0, '0};
        plan.push_back(r);
    endfunction

    initial begin
        mass_reg  = MASS_RESET;
        fric_reg  = FRICTION_RESET;
        vel_state = '{0, 0, 0};

        // rest state: nothing moves, no position given
        plan_tick(mk_tick(0, 0, 0, 0, 0, 0, 0, 1'b0), 1'b1, '0);
        // still body with a position: position passes through
        plan_tick(mk_tick(0, 0, 0, 32'hffff_ffff, FIX_MAX, FIX_MIN, FIX_MAX, 1'b1), 1'b1,
                  '{FIX_MAX, FIX_MIN, FIX_MAX, 0, 0, 0});
        // full force over unit mass, with no friction at zero time step, then a unit step
        plan_tick(mk_tick(FIX_MAX, 0, 0, 0, 0, 0, 0, 1'b0), 1'b1,
                  '{0, 0, 0, FIX_MAX, 0, 0});
        plan_tick(mk_tick(FIX_MIN, 0, 0, 0, 0, 0, 0, 1'b0), 1'b1,
                  '{0, 0, 0, -1, 0, 0});
        plan_tick(mk_tick(0, FIX_MIN, FIX_MAX, ONE, 0, 0, 0, 1'b1), 1'b0, '0);
        // friction slows the moving body
        plan_tick(mk_tick(0, 0, 0, ONE, ONE, ONE, ONE, 1'b1), 1'b0, '0);
        plan_write(CFG_FRICTION, 0);
        plan_tick(mk_tick(ONE, -2 * ONE, 3 * ONE, 32'h8000, FIX_MAX, FIX_MIN, 0, 1'b1),
                  1'b0, '0);
        plan_tick(mk_tick(FIX_MAX, FIX_MAX, FIX_MAX, 32'hffff_ffff, FIX_MIN, FIX_MIN,
                          FIX_MAX, 1'b1), 1'b0, '0);
        // zero mass: acceleration saturates, friction vanishes
        plan_write(CFG_MASS, 0);
        plan_tick(mk_tick(5, -5, 0, 32'h100, 0, 0, 0, 1'b1), 1'b0, '0);
        plan_write(CFG_MASS, 32'hffff_ffff);
        plan_tick(mk_tick(FIX_MAX, FIX_MIN, 1, 32'h1000, 0, 0, 0, 1'b1), 1'b0, '0);
        plan_write(CFG_FRICTION, 32'hffff_ffff);
        plan_tick(mk_tick(ONE, ONE, ONE, 32'hffff_ffff, 0, 0, 0, 1'b1), 1'b0, '0);
        // unmapped indexes are dropped
        plan_write(CFG_SPARE_A, 32'h0000_0001);
        plan_write(CFG_SPARE_B, 32'hdead_beef);
        plan_write(CFG_MASS, MASS_RESET);
        plan_write(CFG_FRICTION, FRICTION_RESET);
        // moving body slowed along its direction
        plan_tick(mk_tick(3 * ONE, 4 * ONE, 0, 32'h10, 0, 0, 0, 1'b1), 1'b0, '0);
        plan_tick(mk_tick(0, 0, -ONE, 32'h10, 32'h1234, -32'sh1234, 0, 1'b1), 1'b0, '0);

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[k]) begin
            if (plan[k].is_write) begin
                write_reg(plan[k].idx, plan[k].value);
            end else begin
                send_tick(plan[k].tick, plan[k].typed, plan[k].want);
            end
        end

        // Random phases, each under its own mass and friction
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    write_reg(CFG_MASS, MASS_RESET);
                    write_reg(CFG_FRICTION, FRICTION_RESET);
                end
                1: begin
                    write_reg(CFG_MASS, 1);
                    write_reg(CFG_FRICTION, 0);
                end
                2: begin
                    write_reg(CFG_MASS, 32'hffff_ffff);
                    write_reg(CFG_FRICTION, $urandom_range(0, 32'h0010_0000));
                end
                3: begin
                    write_reg(CFG_MASS, 0);
                    write_reg(CFG_FRICTION, 32'hffff_ffff);
                end
                default: begin
                    write_reg(CFG_MASS, $urandom());
                    write_reg(CFG_FRICTION, $urandom_range(0, 1) ? $urandom()
                                                                 : $urandom_range(0, 32'h0100_0000));
                end
            endcase
            for (int n = 0; n < RANDOM_TICKS / 6; n++) begin
                if (ph == 5 && n >= RANDOM_TICKS / 6 - CALM_TAIL) calm = 1'b1;
                send_tick(rand_tick(), 1'b0, '0);
            end
        end
        s_valid <= 1'b0;

        wait (body_states_due.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("%0d tick beats sent, %0d results checked, %0d register writes",
                 ticks_sent, states_seen, reg_writes);
        $display("mismatches: %0d", mismatches);
        if (mismatches == 0) begin
            $display("rigid_body_friction_integrator regression: pass");
        end else begin
            $display("rigid_body_friction_integrator regression: fail");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/rbfi_pkg.sv
rtl/rbfi_datapath.sv
rtl/rbfi_ctrl.sv
rtl/rigid_body_friction_integrator.sv
verif/tb_rigid_body_friction_integrator.sv
